FILE: src/script_sigop_counter_unit_defines.svh
// ----------------------------------------------------------------------------
// Script sigop counter assertion macros
// Shared concurrent assertion forms used by the counter modules.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_SIGOP_COUNTER_UNIT_DEFINES_SVH
`define SCRIPT_SIGOP_COUNTER_UNIT_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define SCU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define SCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/scu_pkg.sv
// ----------------------------------------------------------------------------
// Script sigop counter package
// Shared types and constants of the script sigop counter.
// ----------------------------------------------------------------------------
package scu_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned COUNT_W       = 19;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned IN_TDATA_W    = 8;
    localparam int unsigned OUT_TDATA_W   = 24;

    localparam longint unsigned MAX_SCRIPT_BYTES = 16384;
    localparam longint unsigned COUNT_HW_MAX     = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned CAP_RAW          = MAX_SCRIPT_BYTES * 20;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((CAP_RAW > COUNT_HW_MAX) ? COUNT_HW_MAX : CAP_RAW);

    localparam logic [4:0] MULTISIG_DEFAULT = 5'd20;

    localparam logic [BYTE_W-1:0] OP_PUSH_MIN     = 8'h01;
    localparam logic [BYTE_W-1:0] OP_PUSH_MAX     = 8'h4b;
    localparam logic [BYTE_W-1:0] OP_LEN1_PUSH    = 8'h4c;
    localparam logic [BYTE_W-1:0] OP_LEN2_PUSH    = 8'h4d;
    localparam logic [BYTE_W-1:0] OP_LEN4_PUSH    = 8'h4e;
    localparam logic [BYTE_W-1:0] OP_1            = 8'h51;
    localparam logic [BYTE_W-1:0] OP_16           = 8'h60;
    localparam logic [BYTE_W-1:0] OP_N_BASE       = 8'h50;
    localparam logic [BYTE_W-1:0] OP_SIGCHK       = 8'hac;
    localparam logic [BYTE_W-1:0] OP_SIGCHK_VFY   = 8'had;
    localparam logic [BYTE_W-1:0] OP_CHECKMULTI   = 8'hae;
    localparam logic [BYTE_W-1:0] OP_CHECKMULTIVF = 8'haf;

    typedef struct packed {
        logic [BYTE_W-1:0] script_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic               truncated;
        logic [COUNT_W-1:0] sigop_count;
    } result_t;

endpackage

FILE: src/scu_in_stage.sv
// ----------------------------------------------------------------------------
// Script sigop counter input stage
// Registers each accepted input word ahead of the parser.
// ----------------------------------------------------------------------------
module scu_in_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scu_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] script_byte
    input  logic                               s_tlast,   // last_byte
    input  logic                               advance,
    output logic                               word_valid,
    output scu_pkg::in_word_t                  word
);
    import scu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg.script_byte <= s_tdata[BYTE_W-1:0];
            word_reg.last_byte   <= s_tlast;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

FILE: src/scu_parser.sv
// ----------------------------------------------------------------------------
// Script sigop counter parser
// Opcode parser, push skipper and saturating signature operation counter.
// ----------------------------------------------------------------------------
`include "script_sigop_counter_unit_defines.svh"

module scu_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              step,
    input  scu_pkg::in_word_t word,
    output logic              result_valid,
    output scu_pkg::result_t  result
);
    import scu_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_SKIP
    } phase_t;

    phase_t             phase_reg, phase_next, phase_parse;
    logic [2:0]         left_reg, left_next, left_dec;
    logic [LEN_W-1:0]   push_reg, push_next, push_merged;
    logic [LEN_W-1:0]   skip_reg, skip_next, skip_dec;
    logic [BYTE_W-1:0]  prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next, count_parse;
    logic               accurate_reg;
    logic [4:0]         add_amount;
    logic [COUNT_W:0]   count_sum;
    logic [BYTE_W-1:0]  op;
    logic [BYTE_W-1:0]  prev_n;

    assign op       = word.script_byte;
    assign left_dec = left_reg - 3'd1;
    assign skip_dec = skip_reg - LEN_W'(1);
    assign prev_n   = prev_reg - OP_N_BASE;

    always_comb
    begin
        if (op == OP_SIGCHK || op == OP_SIGCHK_VFY)
        begin
            add_amount = 5'd1;
        end
        else if (op == OP_CHECKMULTI || op == OP_CHECKMULTIVF)
        begin
            if (accurate_reg && prev_valid_reg && prev_reg >= OP_1 && prev_reg <= OP_16)
            begin
                add_amount = prev_n[4:0];
            end
            else
            begin
                add_amount = MULTISIG_DEFAULT;
            end
        end
        else
        begin
            add_amount = 5'd0;
        end
    end

    assign count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(add_amount);

    always_comb
    begin
        unique case (phase_reg)
            PH_LEN1: push_merged = push_reg | (LEN_W'(op) << 8);
            PH_LEN2: push_merged = push_reg | (LEN_W'(op) << 16);
            PH_LEN3: push_merged = push_reg | (LEN_W'(op) << 24);
            default: push_merged = push_reg | LEN_W'(op);
        endcase
    end

    always_comb
    begin
        phase_parse     = phase_reg;
        left_next       = left_reg;
        push_next       = push_reg;
        skip_next       = skip_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        count_parse     = count_reg;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                count_parse     = (count_sum > (COUNT_W + 1)'(COUNT_CAP)) ?
                                  COUNT_CAP : count_sum[COUNT_W-1:0];
                prev_next       = op;
                prev_valid_next = 1'b1;
                if (op >= OP_PUSH_MIN && op <= OP_PUSH_MAX)
                begin
                    skip_next   = LEN_W'(op);
                    phase_parse = PH_SKIP;
                end
                else if (op >= OP_LEN1_PUSH && op <= OP_LEN4_PUSH)
                begin
                    left_next   = (op == OP_LEN1_PUSH) ? 3'd1 :
                                  (op == OP_LEN2_PUSH) ? 3'd2 : 3'd4;
                    push_next   = '0;
                    phase_parse = PH_LEN0;
                end
            end
            PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
            begin
                push_next = push_merged;
                left_next = left_dec;
                if (left_dec == 3'd0)
                begin
                    if (push_merged == '0)
                    begin
                        phase_parse = PH_OPCODE;
                    end
                    else
                    begin
                        skip_next   = push_merged;
                        phase_parse = PH_SKIP;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LEN0: phase_parse = PH_LEN1;
                        PH_LEN1: phase_parse = PH_LEN2;
                        default: phase_parse = PH_LEN3;
                    endcase
                end
            end
            default:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_parse = PH_OPCODE;
                end
            end
        endcase

        phase_next = phase_parse;
        count_next = count_parse;
        if (word.last_byte)
        begin
            phase_next      = PH_OPCODE;
            left_next       = '0;
            push_next       = '0;
            skip_next       = '0;
            prev_next       = '0;
            prev_valid_next = 1'b0;
            count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPCODE;
            left_reg       <= '0;
            push_reg       <= '0;
            skip_reg       <= '0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
            accurate_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                accurate_reg <= cfg_wr_data;
            end
            if (step)
            begin
                phase_reg      <= phase_next;
                left_reg       <= left_next;
                push_reg       <= push_next;
                skip_reg       <= skip_next;
                prev_reg       <= prev_next;
                prev_valid_reg <= prev_valid_next;
                count_reg      <= count_next;
            end
        end
    end

    assign result_valid       = step && word.last_byte;
    assign result.sigop_count = count_parse;
    assign result.truncated   = (phase_parse != PH_OPCODE);

    `SCU_ASSERT_SAME(a_count_capped, 1'b1, count_reg <= COUNT_CAP, "count above cap")
    `SCU_ASSERT_SAME(a_skip_nonzero, phase_reg == PH_SKIP, skip_reg != '0, "empty skip")
    `SCU_ASSERT_SAME(a_len_left, phase_reg != PH_OPCODE && phase_reg != PH_SKIP,
                     left_reg != 3'd0, "no length bytes left in length phase")
    `SCU_ASSERT_NEXT(a_clear_after_last, step && word.last_byte,
                     phase_reg == PH_OPCODE && count_reg == '0 && !prev_valid_reg,
                     "parser not cleared after last word")

endmodule

FILE: src/scu_out_stage.sv
// ----------------------------------------------------------------------------
// Script sigop counter output stage
// Result register that holds each result word until the receiver takes it.
// ----------------------------------------------------------------------------
module scu_out_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  scu_pkg::result_t                   result,
    output logic                               free,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scu_pkg::OUT_TDATA_W-1:0]    m_tdata    // [18:0] sigop_count, [19] truncated
);
    import scu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result_reg);

endmodule

FILE: src/script_sigop_counter_unit.sv
// ----------------------------------------------------------------------------
// Script sigop counter unit
// Counts legacy signature operations of a byte-serial script.
//
// Script bytes arrive on the s_t* channel, one byte per word, with s_tlast
// set on the final byte of a script. For each script one result word leaves
// on the m_t* channel, carrying the saturated sigop count and a flag that
// is set when the script ended inside a push.
// An accepted byte sits in the input register while the parser works on it;
// a script's result is loaded as its last byte leaves. The unit takes one
// byte per cycle unless a last byte waits for the result register; the
// parser state update is the single stage between input and result registers.
// While the receiver stalls, the result register holds its word and bytes
// keep flowing until another last byte reaches the parser; then s_tready
// drops until the result register frees up.
// The accurate multisig mode bit is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while the unit is idle (not enforced).
// Reset clears the parser and both channels, and sets the mode bit to accurate.
// ----------------------------------------------------------------------------
module script_sigop_counter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scu_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] script_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scu_pkg::OUT_TDATA_W-1:0]    m_tdata    // [18:0] sigop_count, [19] truncated
);
    import scu_pkg::*;

    logic     word_valid;
    in_word_t word;
    logic     advance;
    logic     out_free;
    logic     result_valid;
    result_t  result;

    assign advance = word_valid && (!word.last_byte || out_free);

    scu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    scu_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .step         (advance),
        .word         (word),
        .result_valid (result_valid),
        .result       (result)
    );

    scu_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (result_valid),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: dv/script_sigop_counter_unit_checker.sv
// ----------------------------------------------------------------------------
// Script sigop counter checker
// Watches the configuration port and both stream channels of the counter.
// Every accepted script byte runs through a parser model of its own; on the
// last byte of a script the expected count and truncation flag are queued,
// and each result word leaving the unit is compared with the oldest entry.
// ----------------------------------------------------------------------------
module script_sigop_counter_unit_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [scu_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] script_byte
    input  logic                            s_tlast,   // last_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [scu_pkg::OUT_TDATA_W-1:0] m_tdata,   // [18:0] sigop_count, [19] truncated
    output int                              pending_results,
    output int                              mismatch_count
);
    import scu_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_LEN0   = 3'd1,
        PH_LEN1   = 3'd2,
        PH_LEN2   = 3'd3,
        PH_LEN3   = 3'd4,
        PH_SKIP   = 3'd5
    } parse_phase_t;

    localparam longint unsigned SIGOP_LIMIT_RAW = MAX_SCRIPT_BYTES * 20;
    localparam logic [COUNT_W-1:0] SIGOP_LIMIT =
        COUNT_W'((SIGOP_LIMIT_RAW > 64'd524287) ? 64'd524287 : SIGOP_LIMIT_RAW);

    logic               accurate_mode;
    parse_phase_t       phase;
    logic [2:0]         len_bytes_left;
    logic [LEN_W-1:0]   push_len;
    logic [LEN_W-1:0]   skip_left;
    logic [BYTE_W-1:0]  prev_op;
    logic               prev_op_valid;
    logic [COUNT_W-1:0] sigops;
    result_t            expected_counts[$];
    int                 mismatches;

    task automatic clear_parser();
        phase          = PH_OPCODE;
        len_bytes_left = '0;
        push_len       = '0;
        skip_left      = '0;
        prev_op        = '0;
        prev_op_valid  = 1'b0;
        sigops         = '0;
    endtask

    task automatic add_sigops(input logic [4:0] n);
        logic [COUNT_W:0] sum;
        sum    = {1'b0, sigops} + n;
        sigops = (sum > {1'b0, SIGOP_LIMIT}) ? SIGOP_LIMIT : sum[COUNT_W-1:0];
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t res;
        case (phase)
            PH_OPCODE:
            begin
                if (b == OP_SIGCHK || b == OP_SIGCHK_VFY)
                begin
                    add_sigops(5'd1);
                end
                else if (b == OP_CHECKMULTI || b == OP_CHECKMULTIVF)
                begin
                    if (accurate_mode && prev_op_valid && prev_op >= OP_1 && prev_op <= OP_16)
                        add_sigops(5'(prev_op - OP_N_BASE));
                    else
                        add_sigops(MULTISIG_DEFAULT);
                end
                prev_op       = b;
                prev_op_valid = 1'b1;
                if (b >= OP_PUSH_MIN && b <= OP_PUSH_MAX)
                begin
                    skip_left = LEN_W'(b);
                    phase     = PH_SKIP;
                end
                else if (b >= OP_LEN1_PUSH && b <= OP_LEN4_PUSH)
                begin
                    len_bytes_left = (b == OP_LEN1_PUSH) ? 3'd1 :
                                     (b == OP_LEN2_PUSH) ? 3'd2 : 3'd4;
                    push_len       = '0;
                    phase          = PH_LEN0;
                end
            end
            PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
            begin
                push_len       = push_len | (LEN_W'(b) << (8 * (phase - PH_LEN0)));
                len_bytes_left = len_bytes_left - 3'd1;
                if (len_bytes_left == 3'd0)
                begin
                    if (push_len == '0)
                    begin
                        phase = PH_OPCODE;
                    end
                    else
                    begin
                        skip_left = push_len;
                        phase     = PH_SKIP;
                    end
                end
                else
                begin
                    phase = parse_phase_t'(phase + 3'd1);
                end
            end
            default:
            begin
                if (skip_left != '0)
                    skip_left = skip_left - 1;
                if (skip_left == '0)
                    phase = PH_OPCODE;
            end
        endcase

        if (last)
        begin
            res.sigop_count = sigops;
            res.truncated   = (phase != PH_OPCODE);
            expected_counts.insert(expected_counts.size(), res);
            clear_parser();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            accurate_mode = 1'b1;
            clear_parser();
            expected_counts.delete();
            mismatches      = 0;
            pending_results <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                accurate_mode = cfg_wr_data;

            if (s_tvalid && s_tready)
                parse_byte(s_tdata[BYTE_W-1:0], s_tlast);

            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[COUNT_W:0]);
                if (expected_counts.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Result word with nothing expected: count %0d truncated %0b",
                                 got.sigop_count, got.truncated);
                    mismatches++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (got.sigop_count != want.sigop_count || got.truncated != want.truncated)
                    begin
                        if (mismatches < 10)
                            $display("Result mismatch: expected %0d/%0b, got %0d/%0b",
                                     want.sigop_count, want.truncated,
                                     got.sigop_count, got.truncated);
                        mismatches++;
                    end
                end
            end

            pending_results <= expected_counts.size();
            mismatch_count  <= mismatches;
        end
    end

endmodule

FILE: dv/script_sigop_counter_unit_test.sv
// ----------------------------------------------------------------------------
// Script sigop counter testbench
// Drives scripts into the counter with random gaps on both channels: a set
// of directed scripts for each opcode class and corner case, a long multisig
// script, a burst against a long receiver stall, and random scripts that are
// mostly well formed. The mode bit is switched between phases while the unit
// is idle. The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module script_sigop_counter_unit_test;

    import scu_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic                   cfg_wr_data = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tlast     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int                     pending_results;
    int                     mismatch_count;
    int                     cycle_count    = 0;
    int                     bytes_sent     = 0;
    int                     rx_hold_cycles = 0;
    bit                     tx_no_gap      = 1'b0;
    logic [BYTE_W-1:0]      script_q[$];

    always #6 clk = ~clk;

    script_sigop_counter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    script_sigop_counter_unit_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        script_q.insert(script_q.size(), b);
    endtask

    task automatic send_script();
        int gap;
        for (int i = 0; i < script_q.size(); i++)
        begin
            gap = tx_no_gap ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= script_q[i];
            s_tlast  <= (i == script_q.size() - 1);
            do @(posedge clk); while (!s_tready);
            bytes_sent++;
        end
        script_q.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic accurate);
        wait_drained();
        repeat (6) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= accurate;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_data(input int n);
        for (int i = 0; i < n; i++)
            put_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic add_pushdata(input logic [BYTE_W-1:0] op, input int len);
        int nlen;
        nlen = (op == OP_LEN1_PUSH) ? 1 : (op == OP_LEN2_PUSH) ? 2 : 4;
        put_byte(op);
        for (int i = 0; i < nlen; i++)
            put_byte(BYTE_W'(len >> (8 * i)));
        add_data(len);
    endtask

    task automatic build_script();
        int               shape;
        int               len;
        int               nlen;
        logic [BYTE_W-1:0] b;
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            add_data($urandom_range(1, 24));
            return;
        end
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(0, 9))
                0: put_byte($urandom_range(0, 1) ? OP_SIGCHK : OP_SIGCHK_VFY);
                1:
                begin
                    put_byte(BYTE_W'(OP_1 + $urandom_range(0, 15)));
                    put_byte($urandom_range(0, 1) ? OP_CHECKMULTI : OP_CHECKMULTIVF);
                end
                2: put_byte($urandom_range(0, 1) ? OP_CHECKMULTI : OP_CHECKMULTIVF);
                3:
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 75) :
                                                        $urandom_range(1, 6);
                    put_byte(BYTE_W'(len));
                    add_data(len);
                end
                4:
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) :
                                                         $urandom_range(0, 10);
                    add_pushdata(OP_LEN1_PUSH, len);
                end
                5:
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 300) :
                                                         $urandom_range(0, 10);
                    add_pushdata(OP_LEN2_PUSH, len);
                end
                6: add_pushdata(OP_LEN4_PUSH, $urandom_range(0, 10));
                7: put_byte(BYTE_W'(OP_1 + $urandom_range(0, 15)));
                default:
                begin
                    do b = BYTE_W'($urandom_range(0, 255));
                    while (b >= OP_PUSH_MIN && b <= OP_LEN4_PUSH);
                    put_byte(b);
                end
            endcase
        end
        if (shape == 1)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    len = $urandom_range(2, 75);
                    put_byte(BYTE_W'(len));
                    add_data($urandom_range(0, len - 1));
                end
                1:
                begin
                    b    = BYTE_W'(OP_LEN1_PUSH + $urandom_range(0, 2));
                    nlen = (b == OP_LEN1_PUSH) ? 1 : (b == OP_LEN2_PUSH) ? 2 : 4;
                    put_byte(b);
                    add_data($urandom_range(0, nlen - 1));
                end
                2:
                begin
                    put_byte(OP_LEN4_PUSH);
                    add_data(3);
                    put_byte(BYTE_W'($urandom_range(1, 255)));
                    add_data($urandom_range(0, 5));
                end
                default:
                begin
                    len = $urandom_range(1, 65535);
                    put_byte(OP_LEN2_PUSH);
                    put_byte(BYTE_W'(len));
                    put_byte(BYTE_W'(len >> 8));
                    add_data($urandom_range(0, (len - 1 < 6) ? len - 1 : 6));
                end
            endcase
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
        begin
            build_script();
            tx_no_gap = ($urandom_range(0, 4) == 0);
            send_script();
        end
        tx_no_gap = 1'b0;
    endtask

    initial
    begin
        int gap;
        int hold;
        int rx_fast_left;
        rx_fast_left = 0;
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else
            begin
                if (rx_fast_left > 0)
                begin
                    gap = 0;
                    rx_fast_left--;
                end
                else
                begin
                    gap = $urandom_range(0, 17);
                    if ($urandom_range(0, 15) == 0)
                        rx_fast_left = $urandom_range(4, 16);
                end
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Accurate mode as left by reset.
        script_q = '{OP_SIGCHK};                         send_script();
        script_q = '{OP_SIGCHK_VFY, OP_CHECKMULTI};      send_script();
        script_q = '{OP_1, OP_CHECKMULTI};               send_script();
        script_q = '{OP_16, OP_CHECKMULTIVF};            send_script();
        script_q = '{OP_N_BASE, OP_CHECKMULTI};          send_script();
        script_q = '{8'h00};                             send_script();
        script_q = '{8'hff};                             send_script();
        script_q = '{8'h02, OP_SIGCHK, OP_SIGCHK, OP_SIGCHK}; send_script();
        script_q = '{OP_LEN1_PUSH, 8'h00, OP_SIGCHK};    send_script();
        script_q = '{OP_LEN2_PUSH, 8'h01, 8'h00, 8'hac, OP_SIGCHK_VFY}; send_script();
        script_q = '{OP_LEN4_PUSH, 8'h00, 8'h00, 8'h00, 8'h00, OP_SIGCHK}; send_script();
        script_q = '{OP_PUSH_MAX, OP_SIGCHK};            send_script();
        script_q = '{OP_LEN1_PUSH};                      send_script();
        script_q = '{OP_PUSH_MIN};                       send_script();

        set_mode(1'b0);
        script_q = '{8'h52, OP_CHECKMULTI};              send_script();
        script_q = '{OP_16, OP_CHECKMULTIVF};            send_script();
        // One long run of multisig opcodes sent without gaps.
        for (int i = 0; i < 40; i++)
            put_byte(OP_CHECKMULTI);
        put_byte(OP_SIGCHK);
        tx_no_gap = 1'b1;
        send_script();
        tx_no_gap = 1'b0;

        set_mode(1'b1);
        // Short scripts back to back against a long receiver stall.
        rx_hold_cycles = 300;
        tx_no_gap      = 1'b1;
        repeat (16)
        begin
            case ($urandom_range(0, 2))
                0: script_q = '{OP_SIGCHK};
                1: script_q = '{BYTE_W'(OP_1 + $urandom_range(0, 15)), OP_CHECKMULTI};
                default: add_data($urandom_range(1, 3));
            endcase
            send_script();
        end
        tx_no_gap = 1'b0;
        run_random(570);

        set_mode(1'b0);
        run_random(570);

        set_mode(1'b1);
        run_random(570);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
